// File: src/cbf_pkg.sv
`timescale 1ns / 1ps

package cbf_pkg;

  // coordinate and count formats
  localparam int unsigned CoordW        = 24;
  localparam int unsigned SegCountW     = 7;
  localparam int unsigned MaxSegmentsDef = 64;
  // curve parameter t runs 0 .. 2^16 inclusive
  localparam int unsigned TW            = 17;
  localparam logic [TW-1:0] TOne        = 17'h10000;
  // power-basis coefficients and horner accumulator
  localparam int unsigned CoefW         = 28;
  localparam int unsigned HornerW       = 80;
  localparam int unsigned HMulW         = 63;
  localparam int unsigned RoundShift    = 48;

  typedef enum logic [1:0] {
    ReqMove  = 2'd0,
    ReqLine  = 2'd1,
    ReqCubic = 2'd2,
    ReqEnd   = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic signed [CoordW-1:0]  dest_x;
    logic signed [CoordW-1:0]  dest_y;
    logic signed [CoordW-1:0]  ctrl1_x;
    logic signed [CoordW-1:0]  ctrl1_y;
    logic signed [CoordW-1:0]  ctrl2_x;
    logic signed [CoordW-1:0]  ctrl2_y;
    logic [SegCountW-1:0]      segment_count;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0]  point_x;
    logic signed [CoordW-1:0]  point_y;
    logic                      last;
  } pt_t;

  // horner passes: t^3 term folds in B, then C, then the start point
  typedef enum logic [1:0] {
    HsQuad  = 2'd0,
    HsLin   = 2'd1,
    HsConst = 2'd2
  } hstep_e;

  // controller to datapath
  typedef struct packed {
    logic   load;
    logic   step;
    logic   mul;
    hstep_e hstep;
    logic   take;
    logic   push;
    logic   push_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_type_e kind;
    logic      distinct;
    logic      last_step;
    logic      pend_valid;
    logic      out_free;
  } sts_t;

  // floor(65536 / n) for n = 1 .. 64
  function automatic logic [TW-1:0] recip_q(input logic [SegCountW-1:0] n);
    logic [TW-1:0] q;
    unique case (n)
      7'd1:  q = 17'd65536;  7'd2:  q = 17'd32768;  7'd3:  q = 17'd21845;
      7'd4:  q = 17'd16384;  7'd5:  q = 17'd13107;  7'd6:  q = 17'd10922;
      7'd7:  q = 17'd9362;   7'd8:  q = 17'd8192;   7'd9:  q = 17'd7281;
      7'd10: q = 17'd6553;   7'd11: q = 17'd5957;   7'd12: q = 17'd5461;
      7'd13: q = 17'd5041;   7'd14: q = 17'd4681;   7'd15: q = 17'd4369;
      7'd16: q = 17'd4096;   7'd17: q = 17'd3855;   7'd18: q = 17'd3640;
      7'd19: q = 17'd3449;   7'd20: q = 17'd3276;   7'd21: q = 17'd3120;
      7'd22: q = 17'd2978;   7'd23: q = 17'd2849;   7'd24: q = 17'd2730;
      7'd25: q = 17'd2621;   7'd26: q = 17'd2520;   7'd27: q = 17'd2427;
      7'd28: q = 17'd2340;   7'd29: q = 17'd2259;   7'd30: q = 17'd2184;
      7'd31: q = 17'd2114;   7'd32: q = 17'd2048;   7'd33: q = 17'd1985;
      7'd34: q = 17'd1927;   7'd35: q = 17'd1872;   7'd36: q = 17'd1820;
      7'd37: q = 17'd1771;   7'd38: q = 17'd1724;   7'd39: q = 17'd1680;
      7'd40: q = 17'd1638;   7'd41: q = 17'd1598;   7'd42: q = 17'd1560;
      7'd43: q = 17'd1524;   7'd44: q = 17'd1489;   7'd45: q = 17'd1456;
      7'd46: q = 17'd1424;   7'd47: q = 17'd1394;   7'd48: q = 17'd1365;
      7'd49: q = 17'd1337;   7'd50: q = 17'd1310;   7'd51: q = 17'd1285;
      7'd52: q = 17'd1260;   7'd53: q = 17'd1236;   7'd54: q = 17'd1213;
      7'd55: q = 17'd1191;   7'd56: q = 17'd1170;   7'd57: q = 17'd1149;
      7'd58: q = 17'd1129;   7'd59: q = 17'd1110;   7'd60: q = 17'd1092;
      7'd61: q = 17'd1074;   7'd62: q = 17'd1057;   7'd63: q = 17'd1040;
      7'd64: q = 17'd1024;
      default: q = TOne;
    endcase
    return q;
  endfunction

endpackage

// File: src/cbf_ctrl.sv
`timescale 1ns / 1ps

module cbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cbf_pkg::sts_t sts_i,
  output cbf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StStep,
    StMul,
    StCheck,
    StFlush
  } state_e;

  state_e          state_q, state_d;
  cbf_pkg::hstep_e hstep_q, hstep_d;
  logic            open_q, open_d;

  // input side is only open between items
  assign in_stall_o = (state_q != StIdle);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    hstep_d = hstep_q;
    open_d  = open_q;
    cmd_o   = '0;
    cmd_o.hstep = hstep_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        unique case (sts_i.kind)
          cbf_pkg::ReqMove: begin
            open_d  = 1'b1;
            state_d = StCheck;
          end
          cbf_pkg::ReqLine: begin
            state_d = open_q ? StCheck : StIdle;
          end
          cbf_pkg::ReqCubic: begin
            state_d = open_q ? StStep : StIdle;
          end
          cbf_pkg::ReqEnd: begin
            open_d  = 1'b0;
            state_d = StIdle;
          end
          default: state_d = StIdle;
        endcase
      end
      StStep: begin
        cmd_o.step = 1'b1;
        hstep_d    = cbf_pkg::HsQuad;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        unique case (hstep_q)
          cbf_pkg::HsQuad:  hstep_d = cbf_pkg::HsLin;
          cbf_pkg::HsLin:   hstep_d = cbf_pkg::HsConst;
          cbf_pkg::HsConst: state_d = StCheck;
          default:          state_d = StCheck;
        endcase
      end
      StCheck: begin
        // a new point displaces the held one, which needs the output slot
        if (!(sts_i.distinct && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.take = sts_i.distinct;
          cmd_o.push = sts_i.distinct && sts_i.pend_valid;
          if (sts_i.kind == cbf_pkg::ReqCubic && !sts_i.last_step) begin
            state_d = StStep;
          end else begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        // held point is the final one of this item
        if (!sts_i.pend_valid) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hstep_q <= cbf_pkg::HsQuad;
      open_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hstep_q <= hstep_d;
      open_q  <= open_d;
    end
  end

  // a point is only pushed into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free)
    else $error("point pushed into a full output register");

  // nothing is held back between items
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !sts_i.pend_valid)
    else $error("held point left over after item");

  // a displaced held point always finds the output slot free
  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && sts_i.pend_valid) |-> sts_i.out_free)
    else $error("held point overwritten while output register is full");

endmodule

// File: src/cbf_dp.sv
`timescale 1ns / 1ps

module cbf_dp #(
  parameter int unsigned MaxSegments = cbf_pkg::MaxSegmentsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbf_pkg::req_t in_req_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output cbf_pkg::pt_t  out_pt_o,
  input  cbf_pkg::cmd_t cmd_i,
  output cbf_pkg::sts_t sts_o
);

  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned CW   = cbf_pkg::CoordW;
  localparam int unsigned KW   = cbf_pkg::CoefW;
  localparam int unsigned HW   = cbf_pkg::HornerW;
  localparam int unsigned TW   = cbf_pkg::TW;

  function automatic logic signed [KW-1:0] ext(input logic signed [CW-1:0] v);
    return {{(KW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [KW-1:0] x3(input logic signed [KW-1:0] v);
    return v + (v <<< 1);
  endfunction

  // item registers
  cbf_pkg::req_type_e      kind_q;
  logic signed [CW-1:0]    dest_x_q, dest_y_q, s_x_q, s_y_q;
  logic signed [KW-1:0]    a_x_q, b_x_q, c_x_q, a_y_q, b_y_q, c_y_q;
  logic [CntW-1:0]         n_q, i_q, r_q, rem_q;
  logic [TW-1:0]           q_q, t_q;
  logic signed [HW-1:0]    h_x_q, h_y_q;
  // point state
  logic signed [CW-1:0]    cur_x_q, cur_y_q, pend_x_q, pend_y_q;
  logic                    pend_valid_q, out_valid_q;
  cbf_pkg::pt_t            out_q;

  // step count clamp and reciprocal lookup
  logic [cbf_pkg::SegCountW-1:0] n_sat;
  logic [TW-1:0]                 q_load;
  logic [23:0]                   qn;
  logic [CntW-1:0]               rem_load;

  always_comb begin
    if (in_req_i.segment_count == '0) begin
      n_sat = 7'd1;
    end else if (in_req_i.segment_count > 7'(MaxSegments)) begin
      n_sat = 7'(MaxSegments);
    end else begin
      n_sat = in_req_i.segment_count;
    end
  end

  assign q_load   = cbf_pkg::recip_q(n_sat);
  assign qn       = 24'(q_load) * 24'(n_sat);
  assign rem_load = CntW'(24'(cbf_pkg::TOne) - qn);

  // power-basis coefficients from start, control and end points
  logic signed [KW-1:0] a_x_d, b_x_d, c_x_d, a_y_d, b_y_d, c_y_d;

  always_comb begin
    a_x_d = ext(in_req_i.dest_x) - x3(ext(in_req_i.ctrl2_x))
          + x3(ext(in_req_i.ctrl1_x)) - ext(cur_x_q);
    b_x_d = x3(ext(in_req_i.ctrl2_x) - (ext(in_req_i.ctrl1_x) <<< 1) + ext(cur_x_q));
    c_x_d = x3(ext(in_req_i.ctrl1_x) - ext(cur_x_q));
    a_y_d = ext(in_req_i.dest_y) - x3(ext(in_req_i.ctrl2_y))
          + x3(ext(in_req_i.ctrl1_y)) - ext(cur_y_q);
    b_y_d = x3(ext(in_req_i.ctrl2_y) - (ext(in_req_i.ctrl1_y) <<< 1) + ext(cur_y_q));
    c_y_d = x3(ext(in_req_i.ctrl1_y) - ext(cur_y_q));
  end

  // t advance: t += q, remainder carries one extra count
  logic [CntW:0]   r_sum;
  logic            r_wrap;
  logic [TW-1:0]   t_d;
  logic [CntW-1:0] r_d;

  assign r_sum  = {1'b0, r_q} + {1'b0, rem_q};
  assign r_wrap = (r_sum >= {1'b0, n_q});
  assign t_d    = TW'(t_q + q_q + TW'(r_wrap));
  assign r_d    = r_wrap ? CntW'(r_sum - {1'b0, n_q}) : CntW'(r_sum);

  // shared horner multiply-add, one pass per cycle for each axis
  logic signed [cbf_pkg::HMulW-1:0] hm_x, hm_y;
  logic signed [TW:0]               tm;
  logic signed [HW:0]               prod_x, prod_y;
  logic signed [HW-1:0]             add_x, add_y, hn_x, hn_y;

  assign hm_x   = h_x_q[cbf_pkg::HMulW-1:0];
  assign hm_y   = h_y_q[cbf_pkg::HMulW-1:0];
  assign tm     = {1'b0, t_q};
  assign prod_x = hm_x * tm;
  assign prod_y = hm_y * tm;

  always_comb begin
    unique case (cmd_i.hstep)
      cbf_pkg::HsQuad: begin
        add_x = {{(HW-KW-16){b_x_q[KW-1]}}, b_x_q, 16'b0};
        add_y = {{(HW-KW-16){b_y_q[KW-1]}}, b_y_q, 16'b0};
      end
      cbf_pkg::HsLin: begin
        add_x = {{(HW-KW-32){c_x_q[KW-1]}}, c_x_q, 32'b0};
        add_y = {{(HW-KW-32){c_y_q[KW-1]}}, c_y_q, 32'b0};
      end
      cbf_pkg::HsConst: begin
        add_x = {{(HW-CW-48){s_x_q[CW-1]}}, s_x_q, 48'b0};
        add_y = {{(HW-CW-48){s_y_q[CW-1]}}, s_y_q, 48'b0};
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
  end

  assign hn_x = prod_x[HW-1:0] + add_x;
  assign hn_y = prod_y[HW-1:0] + add_y;

  // round to nearest, ties upward, and pick the candidate point
  logic signed [HW-1:0] rnd_x, rnd_y;
  logic signed [CW-1:0] cand_x, cand_y;

  assign rnd_x = h_x_q + (HW'(1) <<< (cbf_pkg::RoundShift - 1));
  assign rnd_y = h_y_q + (HW'(1) <<< (cbf_pkg::RoundShift - 1));

  always_comb begin
    if (kind_q == cbf_pkg::ReqCubic) begin
      cand_x = rnd_x[cbf_pkg::RoundShift +: CW];
      cand_y = rnd_y[cbf_pkg::RoundShift +: CW];
    end else begin
      cand_x = dest_x_q;
      cand_y = dest_y_q;
    end
  end

  // status back to the controller
  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.distinct   = (kind_q == cbf_pkg::ReqMove) ||
                       (cand_x != cur_x_q) || (cand_y != cur_y_q);
    sts_o.last_step  = (i_q == n_q);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // item and curve registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_req_i.req_type;
      dest_x_q <= in_req_i.dest_x;
      dest_y_q <= in_req_i.dest_y;
      s_x_q    <= cur_x_q;
      s_y_q    <= cur_y_q;
      a_x_q    <= a_x_d;
      b_x_q    <= b_x_d;
      c_x_q    <= c_x_d;
      a_y_q    <= a_y_d;
      b_y_q    <= b_y_d;
      c_y_q    <= c_y_d;
      n_q      <= CntW'(n_sat);
      q_q      <= q_load;
      rem_q    <= rem_load;
      i_q      <= '0;
      t_q      <= '0;
      r_q      <= '0;
    end
    if (cmd_i.step) begin
      i_q   <= CntW'(i_q + 1'b1);
      t_q   <= t_d;
      r_q   <= r_d;
      h_x_q <= {{(HW-KW){a_x_q[KW-1]}}, a_x_q};
      h_y_q <= {{(HW-KW){a_y_q[KW-1]}}, a_y_q};
    end else if (cmd_i.mul) begin
      h_x_q <= hn_x;
      h_y_q <= hn_y;
    end
    if (cmd_i.take) begin
      pend_x_q <= cand_x;
      pend_y_q <= cand_y;
    end
    if (cmd_i.push) begin
      out_q.point_x <= pend_x_q;
      out_q.point_y <= pend_y_q;
      out_q.last    <= cmd_i.push_last;
    end
  end

  // current point, held point and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        cur_x_q      <= cand_x;
        cur_y_q      <= cand_y;
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pt_o    = out_q;

  // the final step of a curve lands exactly on t = 1
  a_t_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (CntW'(i_q + 1'b1) == n_q)) |=> (t_q == cbf_pkg::TOne))
    else $error("curve parameter does not reach one at the last step");

  // no step beyond the requested count
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (i_q != n_q))
    else $error("curve step past the segment count");

  // a taken point becomes the current point
  a_take_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |=> (cur_x_q == pend_x_q) && (cur_y_q == pend_y_q) && pend_valid_q)
    else $error("current point out of step with held point");

endmodule

// File: src/cubic_bezier_flattener_top.sv
`timescale 1ns / 1ps
// channel  dir  valid        stall         payload
// in       in   in_valid_i   in_stall_o    cbf_pkg::req_t (move, line, cubic, end)
// out      out  out_valid_o  out_stall_i   cbf_pkg::pt_t  (point, last)
//
// move and open line items pass through decode, check and flush; end and closed
// items go back to idle from decode. a cubic item runs n steps: per step one t update,
// three multiply-add passes of the horner unit (both axes at once) and one compare.
// reset clears the current point to zero and closes the path.
// one point is held back until the next distinct one shows whether it is last;
// a stalled output register holds the item's work, in_stall_o is high during an item.

module cubic_bezier_flattener_top #(
  parameter int unsigned MaxSegments = cbf_pkg::MaxSegmentsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cbf_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cbf_pkg::pt_t  out_pt_o
);

  cbf_pkg::cmd_t cmd;
  cbf_pkg::sts_t sts;

  // sequencer
  cbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // curve arithmetic and point registers
  cbf_dp #(
    .MaxSegments (MaxSegments)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_pt_o    (out_pt_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
